// ----- hw/rtl/stbs_pkg.sv -----
package stbs_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W = 2;
  localparam int IDX_W = 11;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_ANSWERED = 2'd0;
  localparam logic [1:0] STATUS_APPENDED = 2'd1;
  localparam logic [1:0] STATUS_CLEARED  = 2'd2;
  localparam logic [1:0] STATUS_DROPPED  = 2'd3;

  typedef logic [1:0] kind_t;

  // Work kinds after classification by the front end.
  localparam kind_t KIND_APPEND = 2'd0;
  localparam kind_t KIND_QUERY  = 2'd1;
  localparam kind_t KIND_CLEAR  = 2'd2;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- hw/rtl/stbs_front.sv -----
module stbs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [stbs_pkg::OP_W-1:0]          operation,
  input  logic signed [stbs_pkg::DATA_W-1:0] value,
  output logic                               push,
  output stbs_pkg::item_t                    push_item,
  input  stbs_pkg::queue_status_t            q_status
);

  logic            hold_valid;
  stbs_pkg::item_t hold_item;
  stbs_pkg::kind_t kind;

  // Operation 3 has no meaning of its own and runs as a query.
  always_comb begin
    case (operation)
      stbs_pkg::OP_APPEND: kind = stbs_pkg::KIND_APPEND;
      stbs_pkg::OP_CLEAR:  kind = stbs_pkg::KIND_CLEAR;
      default:             kind = stbs_pkg::KIND_QUERY;
    endcase
  end

  assign push      = hold_valid && !q_status.full;
  assign push_item = hold_item;
  assign in_ready  = !hold_valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid      <= 1'b1;
      hold_item.kind  <= kind;
      hold_item.value <= value;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/stbs_queue.sv -----
module stbs_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  stbs_pkg::item_t         push_item,
  input  logic                    pop,
  output stbs_pkg::item_t         pop_item,
  output stbs_pkg::queue_status_t q_status
);

  localparam int DEPTH = 2;

  stbs_pkg::item_t entries [DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign pop_item       = entries[rd_ptr];
  assign q_status.full  = (fill == 2'(DEPTH));
  assign q_status.empty = (fill == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/stbs_back.sv -----
module stbs_back #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  stbs_pkg::item_t                  q_item,
  output logic                             q_pop,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [1:0]                       status,
  output logic [stbs_pkg::IDX_W-1:0]       lower_index,
  output logic [stbs_pkg::IDX_W-1:0]       upper_index,
  output logic [stbs_pkg::IDX_W-1:0]       equal_count
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int XW = (CW > stbs_pkg::IDX_W) ? CW : stbs_pkg::IDX_W;
  localparam int DW = stbs_pkg::DATA_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state;
  logic [CW-1:0]        count;
  logic signed [DW-1:0] key;
  logic [CW-1:0]        lo_l, hie_l, mid_l, mid_l_q;
  logic [CW-1:0]        lo_u, hie_u, mid_u, mid_u_q;
  logic signed [DW-1:0] rd_l, rd_u;
  logic [DW-1:0]        mem [TABLE_DEPTH];
  logic                 done_l, done_u;
  logic                 out_free;
  logic                 room;
  logic                 mem_we;
  logic                 load_out;
  logic [XW-1:0]        lo_ext, up_ext, eq_ext;

  // Each search keeps a half-open window [lo, hie); the bound is hie when it empties.
  assign done_l = !(lo_l < hie_l);
  assign done_u = !(lo_u < hie_u);
  assign mid_l  = lo_l + ((hie_l - lo_l - CW'(1)) >> 1);
  assign mid_u  = lo_u + ((hie_u - lo_u - CW'(1)) >> 1);

  assign out_free = !out_valid || out_ready;
  assign room     = (count < CW'(TABLE_DEPTH));
  assign mem_we   = q_pop && (q_item.kind == stbs_pkg::KIND_APPEND) && room;

  // A new result is loaded either by an append or clear leaving the queue, or
  // by a finished search.
  assign load_out = (state == ST_IDLE && q_pop && q_item.kind != stbs_pkg::KIND_QUERY) ||
                    (state == ST_FIN && out_free);

  assign lo_ext = XW'(hie_l);
  assign up_ext = XW'(hie_u);
  assign eq_ext = up_ext - lo_ext;

  always_comb begin
    q_pop = 1'b0;
    if (state == ST_IDLE && q_valid) begin
      if (q_item.kind == stbs_pkg::KIND_QUERY) begin
        q_pop = 1'b1;
      end else begin
        q_pop = out_free;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= q_item.value;
    end
    rd_l <= mem[mid_l[AW-1:0]];
    rd_u <= mem[mid_u[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_item.kind)
              stbs_pkg::KIND_APPEND: begin
                lower_index <= '0;
                upper_index <= '0;
                equal_count <= '0;
                if (room) begin
                  count  <= count + CW'(1);
                  status <= stbs_pkg::STATUS_APPENDED;
                end else begin
                  status <= stbs_pkg::STATUS_DROPPED;
                end
              end
              stbs_pkg::KIND_CLEAR: begin
                count       <= '0;
                status      <= stbs_pkg::STATUS_CLEARED;
                lower_index <= '0;
                upper_index <= '0;
                equal_count <= '0;
              end
              default: begin
                key   <= q_item.value;
                lo_l  <= '0;
                hie_l <= count;
                lo_u  <= '0;
                hie_u <= count;
                state <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: begin
          mid_l_q <= mid_l;
          mid_u_q <= mid_u;
          if (done_l && done_u) begin
            state <= ST_FIN;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (!done_l) begin
            if (rd_l >= key) begin
              hie_l <= mid_l_q;
            end else begin
              lo_l <= mid_l_q + CW'(1);
            end
          end
          if (!done_u) begin
            if (rd_u > key) begin
              hie_u <= mid_u_q;
            end else begin
              lo_u <= mid_u_q + CW'(1);
            end
          end
          state <= ST_READ;
        end
        ST_FIN: begin
          if (out_free) begin
            status      <= stbs_pkg::STATUS_ANSWERED;
            lower_index <= lo_ext[stbs_pkg::IDX_W-1:0];
            upper_index <= up_ext[stbs_pkg::IDX_W-1:0];
            equal_count <= eq_ext[stbs_pkg::IDX_W-1:0];
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/sorted_table_bound_search.sv -----
// Sorted table bound search. The block holds a table of up to TABLE_DEPTH
// signed 32-bit values that the user appends in non-decreasing order, and
// answers each query key with the lower bound (first index whose value is at
// least the key), the upper bound (first index whose value is above the key)
// and their difference, the number of equal values. Every input transaction
// gives exactly one result transaction, in order: appends answer status 1, or
// status 3 when the table is full and the value is dropped; a clear empties
// the table and answers status 2. For a query, the two searches run side by
// side on two read ports of the table memory, and each halving step costs
// one registered memory read and one compare. Appends and clears are answered
// straight from the idle state of the back end. Input and output have their
// own registers and a two-entry queue between them, so new items are taken
// while a result waits to be picked up.
module sorted_table_bound_search #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [stbs_pkg::OP_W-1:0]          operation,
  input  logic signed [stbs_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [stbs_pkg::IDX_W-1:0]         lower_index,
  output logic [stbs_pkg::IDX_W-1:0]         upper_index,
  output logic [stbs_pkg::IDX_W-1:0]         equal_count
);

  // Front end to queue: one classified transaction per push.
  logic                    push;
  stbs_pkg::item_t         push_item;

  // Queue to back end.
  logic                    pop;
  stbs_pkg::item_t         pop_item;
  stbs_pkg::queue_status_t q_status;

  // The front end registers each transaction and turns the operation code
  // into a work kind; the undefined code is treated as a query.
  stbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .push      (push),
    .push_item (push_item),
    .q_status  (q_status)
  );

  stbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // The back end owns the table memory and the fill count, runs the searches
  // and holds the result register.
  stbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_status.empty),
    .q_item      (pop_item),
    .q_pop       (pop),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .lower_index (lower_index),
    .upper_index (upper_index),
    .equal_count (equal_count)
  );

`ifndef NO_ASSERTIONS
  // The front end never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !q_status.full)
    else $error("push into full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // The equal count is always the difference of the two bounds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (equal_count == stbs_pkg::IDX_W'(upper_index - lower_index)))
    else $error("equal count does not match bounds");

  // Results other than query answers carry zero indices.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != stbs_pkg::STATUS_ANSWERED) |->
      (lower_index == '0 && upper_index == '0))
    else $error("non-query result with nonzero index");
`endif

endmodule

// ----- verif/bound_search_checker.sv -----
// Watches both channels of the bound search block, keeps its own copy of the
// table, predicts the result of every accepted input transaction and compares
// each accepted result transaction against the oldest prediction.
module bound_search_checker #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [stbs_pkg::OP_W-1:0]          operation,
  input  logic signed [stbs_pkg::DATA_W-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         status,
  input  logic [stbs_pkg::IDX_W-1:0]         lower_index,
  input  logic [stbs_pkg::IDX_W-1:0]         upper_index,
  input  logic [stbs_pkg::IDX_W-1:0]         equal_count,
  output int                                 failures,
  output int                                 pending
);

  typedef struct {
    logic [1:0]                 status;
    logic [stbs_pkg::IDX_W-1:0] lower;
    logic [stbs_pkg::IDX_W-1:0] upper;
    logic [stbs_pkg::IDX_W-1:0] count;
  } answer_t;

  logic signed [stbs_pkg::DATA_W-1:0] table_mem [TABLE_DEPTH];
  int                                 table_fill;
  answer_t                            answer_queue [$];
  int                                 mismatch_total;

  initial begin
    failures       = 0;
    pending        = 0;
    table_fill     = 0;
    mismatch_total = 0;
  end

  // First filled index whose entry is at least the key (or above it when
  // strict is set), following the same halving steps as the hardware.
  function automatic int first_index(logic signed [stbs_pkg::DATA_W-1:0] key, bit strict);
    int lo, hi, mid, found;
    lo    = 0;
    hi    = table_fill - 1;
    found = table_fill;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (strict ? (table_mem[mid] > key) : (table_mem[mid] >= key)) begin
        found = mid;
        hi    = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return found;
  endfunction

  function automatic answer_t apply_item(logic [1:0] op, logic signed [stbs_pkg::DATA_W-1:0] key);
    answer_t ans;
    int      lb, ub;
    ans.lower = '0;
    ans.upper = '0;
    ans.count = '0;
    case (op)
      stbs_pkg::OP_APPEND: begin
        if (table_fill < TABLE_DEPTH) begin
          table_mem[table_fill] = key;
          table_fill++;
          ans.status = stbs_pkg::STATUS_APPENDED;
        end else begin
          ans.status = stbs_pkg::STATUS_DROPPED;
        end
      end
      stbs_pkg::OP_CLEAR: begin
        table_fill = 0;
        ans.status = stbs_pkg::STATUS_CLEARED;
      end
      default: begin
        // The undefined operation code is answered as a query.
        lb         = first_index(key, 1'b0);
        ub         = first_index(key, 1'b1);
        ans.lower  = lb[stbs_pkg::IDX_W-1:0];
        ans.upper  = ub[stbs_pkg::IDX_W-1:0];
        ans.count  = ans.upper - ans.lower;
        ans.status = stbs_pkg::STATUS_ANSWERED;
      end
    endcase
    return ans;
  endfunction

  function automatic int field_error(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      answer_queue.delete();
      table_fill = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_queue.size() == 0) begin
          $display("%0t: result with status %0d arrived with nothing outstanding",
                   $time, status);
          mismatch_total++;
        end else begin
          want = answer_queue.pop_front();
          mismatch_total += field_error("status", want.status, status);
          mismatch_total += field_error("lower_index", want.lower, lower_index);
          mismatch_total += field_error("upper_index", want.upper, upper_index);
          mismatch_total += field_error("equal_count", want.count, equal_count);
        end
      end
      if (in_valid && in_ready) begin
        answer_queue.insert(answer_queue.size(), apply_item(operation, value));
      end
    end
    failures <= mismatch_total;
    pending  <= answer_queue.size();
  end

endmodule

// ----- verif/sorted_table_bound_search_test.sv -----
// Top of the bound search testbench. This module only makes stimulus and
// gives the verdict; the checker beside the block predicts and compares.
module sorted_table_bound_search_test;

  localparam int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH;
  localparam int ITEM_TARGET = 1850;
  localparam int FILL_POINT  = 700;
  localparam int CYCLE_LIMIT = 1000000;

  // The package names three operations; the fourth code must act as a query.
  localparam logic [stbs_pkg::OP_W-1:0] OP_UNDEFINED = 2'd3;

  localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [31:0] MOST_POSITIVE = 32'h7fff_ffff;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic [stbs_pkg::OP_W-1:0]          operation;
  logic signed [stbs_pkg::DATA_W-1:0] value;
  logic                               out_valid;
  logic                               out_ready;
  logic [1:0]                         status;
  logic [stbs_pkg::IDX_W-1:0]         lower_index;
  logic [stbs_pkg::IDX_W-1:0]         upper_index;
  logic [stbs_pkg::IDX_W-1:0]         equal_count;

  int failures;
  int pending;
  int cycle_count;
  int items_sent;

  // When set, neither side idles, giving stretches of back-to-back traffic.
  bit steady;

  // What the table should hold, used only to aim query keys at stored values.
  int shadow [$];

  sorted_table_bound_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .lower_index (lower_index),
    .upper_index (upper_index),
    .equal_count (equal_count)
  );

  bound_search_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .lower_index (lower_index),
    .upper_index (upper_index),
    .equal_count (equal_count),
    .failures    (failures),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A correct run finishes far below this count, even with every
  // query at full table depth and every gap and stall at its longest.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Most gaps are zero or a few cycles; now and then a long one lands so that
  // the block sees an empty input while a search is in flight.
  function automatic int pick_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure, chosen at random and sometimes held low for a stretch.
  initial begin
    int hold;
    int r;
    out_ready = 1'b0;
    hold      = 0;
    forever begin
      @(posedge clk);
      if (steady) begin
        out_ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_ready <= 1'b1;
        end else if (r < 95) begin
          out_ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
    end
  end

  // Present one input transaction and return at the edge that accepts it.
  // Valid stays high across back-to-back transactions and is lowered only
  // when a gap is wanted, so it never sees two assignments in one step.
  task automatic send_item(logic [stbs_pkg::OP_W-1:0] op, logic [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == stbs_pkg::OP_APPEND && shadow.size() < TABLE_DEPTH) begin
      shadow.insert(shadow.size(), val);
    end else if (op == stbs_pkg::OP_CLEAR) begin
      shadow.delete();
    end
  endtask

  // Hold the input idle until every outstanding result has been taken.
  // The first edge is waited out so that a transaction accepted at the
  // current edge is already counted as outstanding.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Keys are aimed mostly at stored values and their neighbors, since those
  // are the boundaries where the lower and upper bounds move.
  function automatic logic [31:0] pick_key();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (shadow.size() == 0 || r < 10) begin
      return $urandom;
    end else if (r < 18) begin
      return $urandom_range(0, 1) ? MOST_NEGATIVE : MOST_POSITIVE;
    end
    k = shadow[$urandom_range(0, shadow.size() - 1)];
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return k;
    end else if (r < 75) begin
      return k - 1;
    end
    return k + 1;
  endfunction

  function automatic logic [stbs_pkg::OP_W-1:0] pick_query_op();
    return ($urandom_range(0, 9) == 0) ? OP_UNDEFINED : stbs_pkg::OP_QUERY;
  endfunction

  // Build n values, either spread over the whole range or packed into a
  // window so that runs of equal values appear, sorted unless scrambled.
  task automatic load_values(int n, bit scrambled);
    int loaded [$];
    int base;
    int spread;
    int r;
    r      = $urandom_range(0, 99);
    base   = $urandom;
    spread = (r < 45) ? $urandom_range(0, 4) : $urandom_range(5, 2000);
    repeat (n) begin
      if (r >= 80) begin
        loaded.insert(loaded.size(), $urandom);
      end else begin
        loaded.insert(loaded.size(), base + $urandom_range(0, spread));
      end
    end
    if (!scrambled) begin
      loaded.sort();
    end
    foreach (loaded[i]) begin
      send_item(stbs_pkg::OP_APPEND, loaded[i]);
    end
  endtask

  // A short table followed by a burst of queries. Most sets start from a
  // cleared table; the rest append onto whatever is left, and a few load
  // the table out of order to see that the halving steps still match.
  task automatic run_small_set();
    int n;
    steady = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 99) < 85) begin
      send_item(stbs_pkg::OP_CLEAR, $urandom);
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
    load_values(n, $urandom_range(0, 7) == 0);
    repeat ($urandom_range(3, 12)) begin
      send_item(pick_query_op(), pick_key());
    end
    if ($urandom_range(0, 3) == 0) begin
      wait_for_answers();
    end
    steady = 1'b0;
  endtask

  // Fill the table to its last entry, then push appends past the end, which
  // must be dropped, and query the full table including both extreme keys.
  task automatic fill_whole_table();
    wait_for_answers();
    send_item(stbs_pkg::OP_CLEAR, 32'd0);
    load_values(TABLE_DEPTH, 1'b0);
    send_item(stbs_pkg::OP_APPEND, MOST_NEGATIVE);
    send_item(stbs_pkg::OP_APPEND, MOST_POSITIVE);
    send_item(stbs_pkg::OP_APPEND, $urandom);
    send_item(stbs_pkg::OP_QUERY, MOST_NEGATIVE);
    send_item(stbs_pkg::OP_QUERY, MOST_POSITIVE);
    repeat (30) begin
      send_item(pick_query_op(), pick_key());
    end
    send_item(stbs_pkg::OP_APPEND, $urandom);
    send_item(stbs_pkg::OP_CLEAR, $urandom);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = stbs_pkg::OP_CLEAR;
    value      = '0;
    steady     = 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: an empty table, both extreme values, a run of equal
    // values, keys just outside a run, the undefined operation code, a clear
    // and an out-of-order table.
    send_item(stbs_pkg::OP_QUERY, 32'd0);
    send_item(stbs_pkg::OP_APPEND, MOST_NEGATIVE);
    send_item(stbs_pkg::OP_APPEND, -32'sd5);
    send_item(stbs_pkg::OP_APPEND, -32'sd5);
    send_item(stbs_pkg::OP_APPEND, -32'sd5);
    send_item(stbs_pkg::OP_APPEND, 32'd0);
    send_item(stbs_pkg::OP_APPEND, MOST_POSITIVE);
    send_item(stbs_pkg::OP_QUERY, MOST_NEGATIVE);
    send_item(stbs_pkg::OP_QUERY, -32'sd5);
    send_item(stbs_pkg::OP_QUERY, -32'sd6);
    send_item(stbs_pkg::OP_QUERY, MOST_POSITIVE);
    send_item(stbs_pkg::OP_QUERY, -32'sd1);
    send_item(OP_UNDEFINED, 32'd0);
    send_item(stbs_pkg::OP_QUERY, 32'd1);
    send_item(stbs_pkg::OP_CLEAR, 32'hffff_ffff);
    send_item(stbs_pkg::OP_QUERY, 32'd0);
    send_item(stbs_pkg::OP_APPEND, 32'd5);
    send_item(stbs_pkg::OP_APPEND, 32'd1);
    send_item(stbs_pkg::OP_APPEND, 32'd3);
    send_item(stbs_pkg::OP_QUERY, 32'd3);
    send_item(OP_UNDEFINED, 32'd6);
    send_item(stbs_pkg::OP_CLEAR, 32'd0);

    // Random part, with one pass over the full table partway through. The
    // full-table pass first lets every outstanding result drain.
    while (items_sent < FILL_POINT) begin
      run_small_set();
    end
    fill_whole_table();
    while (items_sent < ITEM_TARGET) begin
      run_small_set();
    end

    wait_for_answers();
    // This tail catches any stray result that shows up after the last expected
    // one.
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
